// ----- rtl/growable_array_with_compaction_assert.svh -----
// assertion macros for the growable array block
`ifndef GROWABLE_ARRAY_WITH_COMPACTION_ASSERT_SVH
`define GROWABLE_ARRAY_WITH_COMPACTION_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define GAWC_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("gawc assertion failed");

// next-cycle implication
`define GAWC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("gawc assertion failed");

`else

`define GAWC_ASSERT_IMPL(label, clk, rst, cond, prop)
`define GAWC_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ----- rtl/gawc_pkg.sv -----
// shared constants and types for the growable array block
package gawc_pkg;

  localparam int DEF_MAX_DEPTH     = 64;
  localparam int DEF_ELEMENT_WIDTH = 32;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 7;
  localparam int CAP_W   = 7;
  localparam int ST_W    = 2;

  localparam int INIT_CAP_RESET = 10;

  // cells per first-level group of the removed-word gather
  localparam int GATHER_GROUP = 8;

  localparam logic [CMD_W-1:0] CMD_APPEND      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE_LAST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT   = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic append;
    logic remove;
  } cell_op_t;

endpackage

// ----- rtl/growable_array_with_compaction.sv -----
// growable array: a compacting chain of cells with doubling and halving capacity
//
// input channel (in_valid / in_stall) carries one command word: command, value,
// position. append writes value at the tail, remove last and remove at position
// take a word out and the cells above the hole shift down one place.
// output channel (out_valid / out_stall) returns one word per command: the
// removed value (zero when nothing is removed), status, count, logical capacity
// and the empty flag, all as they stand after that command.
// out_valid rises when the output register loads: the cells, the counters and
// the gather tree register load at the accept edge, the output register loads
// from them when it is empty or its word is being taken.
// throughput is one command per cycle while the receiver does not stall; the
// output register and the gather stage let a new command in while a finished
// result waits. when the receiver stalls, the result holds and the input
// stalls once the gather stage is also full.
// the config channel (cfg_valid / cfg_ready, always ready) writes the initial
// capacity at once when the list is empty and no command is accepted. reset
// empties the list and loads the capacity with 10, clamped to the depth.
module growable_array_with_compaction #(
  parameter int MAX_DEPTH     = gawc_pkg::DEF_MAX_DEPTH,
  parameter int ELEMENT_WIDTH = gawc_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gawc_pkg::CMD_W-1:0]          command,
  input  logic signed [gawc_pkg::VALUE_W-1:0] value,
  input  logic [gawc_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [gawc_pkg::VALUE_W-1:0] removed_value,
  output logic [gawc_pkg::ST_W-1:0]           status,
  output logic [gawc_pkg::CNT_W-1:0]          count,
  output logic [gawc_pkg::CAP_W-1:0]          logical_capacity,
  output logic                                is_empty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gawc_pkg::CAP_W-1:0]          cfg_data
);

  `include "growable_array_with_compaction_assert.svh"

  localparam int CAP_W   = gawc_pkg::CAP_W;
  localparam int CNT_W   = gawc_pkg::CNT_W;
  localparam int VALUE_W = gawc_pkg::VALUE_W;
  localparam int CIW     = $clog2(MAX_DEPTH + 1);
  localparam int IW      = $clog2(MAX_DEPTH);
  localparam int CMPW    = (CIW > CAP_W) ? CIW : CAP_W;

  localparam logic [CIW-1:0] DEPTH_C   = CIW'(MAX_DEPTH);
  localparam logic [CIW-1:0] CAP_RESET = (gawc_pkg::INIT_CAP_RESET > MAX_DEPTH) ?
                                         CIW'(MAX_DEPTH) :
                                         CIW'(gawc_pkg::INIT_CAP_RESET);

  function automatic logic [CIW-1:0] clamp_cfg(input logic [CAP_W-1:0] v);
    logic [CMPW-1:0] ve;
    ve = CMPW'(v);
    if (v == '0) begin
      return CIW'(1);
    end else if (ve > CMPW'(MAX_DEPTH)) begin
      return DEPTH_C;
    end else begin
      return CIW'(ve);
    end
  endfunction

  logic [CIW-1:0] elem_count;
  logic [CIW-1:0] cap;
  logic [CIW-1:0] count_next;
  logic [CIW-1:0] cap_next;
  logic [CIW-1:0] cap_grown;
  logic [CIW-1:0] cap_halved;
  logic [CIW:0]   cap_dbl;
  logic [CMPW-1:0] pos_e;
  logic [CMPW-1:0] cnt_e;
  logic [gawc_pkg::ST_W-1:0] status_next;
  logic shrink;
  logic in_accept;
  logic advance;

  gawc_pkg::cell_op_t op;
  logic [IW-1:0] rm_idx;
  logic [IW-1:0] tail_idx;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic [MAX_DEPTH-1:0][ELEMENT_WIDTH-1:0] cell_data;
  logic [MAX_DEPTH-1:0][ELEMENT_WIDTH-1:0] cell_pick;
  logic [ELEMENT_WIDTH-1:0] merged;

  logic s1_valid;
  logic [gawc_pkg::ST_W-1:0] s1_status;
  logic [CIW-1:0] s1_count;
  logic [CIW-1:0] s1_cap;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  assign cap_dbl    = {cap, 1'b0};
  assign cap_grown  = (cap_dbl > (CIW + 1)'(MAX_DEPTH)) ? DEPTH_C : CIW'(cap_dbl);
  assign cap_halved = ((cap >> 1) == '0) ? CIW'(1) : (cap >> 1);
  assign tail_idx   = IW'(elem_count);
  assign wdata      = ELEMENT_WIDTH'($unsigned(value));

  always_comb begin
    op          = '0;
    rm_idx      = '0;
    status_next = gawc_pkg::ST_DONE;
    count_next  = elem_count;
    cap_next    = cap;
    shrink      = 1'b0;
    pos_e       = CMPW'(position);
    cnt_e       = CMPW'(elem_count);
    unique case (command)
      gawc_pkg::CMD_APPEND: begin
        if (elem_count == DEPTH_C) begin
          status_next = gawc_pkg::ST_FULL;
        end else begin
          op.append  = 1'b1;
          count_next = elem_count + 1'b1;
          if (elem_count >= cap) begin
            cap_next = cap_grown;
          end
        end
      end
      gawc_pkg::CMD_REMOVE_LAST: begin
        if (elem_count == '0) begin
          status_next = gawc_pkg::ST_IGNORED;
        end else begin
          op.remove  = 1'b1;
          rm_idx     = IW'(elem_count - 1'b1);
          count_next = elem_count - 1'b1;
          shrink     = 1'b1;
        end
      end
      gawc_pkg::CMD_REMOVE_AT: begin
        if ((position == '0) || (pos_e > cnt_e)) begin
          status_next = gawc_pkg::ST_IGNORED;
        end else begin
          op.remove  = 1'b1;
          rm_idx     = IW'(pos_e - 1'b1);
          count_next = elem_count - 1'b1;
          shrink     = 1'b1;
        end
      end
      default: begin
        status_next = gawc_pkg::ST_IGNORED;
      end
    endcase
    // halve once the list drops below a quarter of the capacity
    if (shrink && (count_next < (cap >> 2))) begin
      cap_next = cap_halved;
    end
    if (!in_accept) begin
      op = '0;
    end
  end

  generate
    for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      if (i == MAX_DEPTH - 1) begin : g_top
        gawc_cell #(.INDEX(i), .IW(IW), .EW(ELEMENT_WIDTH)) u_cell (
          .clk        (clk),
          .op         (op),
          .tail_idx   (tail_idx),
          .rm_idx     (rm_idx),
          .wdata      (wdata),
          .upper_data (cell_data[i]),
          .data       (cell_data[i]),
          .pick       (cell_pick[i])
        );
      end else begin : g_mid
        gawc_cell #(.INDEX(i), .IW(IW), .EW(ELEMENT_WIDTH)) u_cell (
          .clk        (clk),
          .op         (op),
          .tail_idx   (tail_idx),
          .rm_idx     (rm_idx),
          .wdata      (wdata),
          .upper_data (cell_data[i + 1]),
          .data       (cell_data[i]),
          .pick       (cell_pick[i])
        );
      end
    end
  endgenerate

  gawc_gather #(.DEPTH(MAX_DEPTH), .EW(ELEMENT_WIDTH)) u_gather (
    .clk    (clk),
    .load   (in_accept),
    .picks  (cell_pick),
    .merged (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      cap        <= CAP_RESET;
    end else if (in_accept) begin
      elem_count <= count_next;
      cap        <= cap_next;
    end else if (cfg_valid && (elem_count == '0)) begin
      cap <= clamp_cfg(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_status <= status_next;
      s1_count  <= count_next;
      s1_cap    <= cap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      removed_value    <= VALUE_W'(merged);
      status           <= s1_status;
      count            <= CNT_W'(s1_count);
      logical_capacity <= CAP_W'(s1_cap);
      is_empty         <= (s1_count == '0);
    end
  end

  `GAWC_ASSERT_IMPL(a_cap_range, clk, rst, 1'b1, (cap != '0) && (cap <= DEPTH_C))
  `GAWC_ASSERT_IMPL(a_full_at_depth, clk, rst,
                    s1_valid && (s1_status == gawc_pkg::ST_FULL), s1_count == DEPTH_C)
  `GAWC_ASSERT_NEXT(a_append_grows, clk, rst,
                    in_accept && (command == gawc_pkg::CMD_APPEND) && (elem_count != DEPTH_C),
                    elem_count == $past(elem_count) + 1'b1)
  `GAWC_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, elem_count <= DEPTH_C)

endmodule

// ----- rtl/gawc_cell.sv -----
// one storage cell of the compacting chain
module gawc_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 6,
  parameter int EW    = 32
) (
  input  logic               clk,
  input  gawc_pkg::cell_op_t op,
  input  logic [IW-1:0]      tail_idx,
  input  logic [IW-1:0]      rm_idx,
  input  logic [EW-1:0]      wdata,
  input  logic [EW-1:0]      upper_data,
  output logic [EW-1:0]      data,
  output logic [EW-1:0]      pick
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  // append lands at the tail, removal pulls every cell at or above the hole down
  always_ff @(posedge clk) begin
    if (op.append && (tail_idx == MY_IDX)) begin
      data <= wdata;
    end else if (op.remove && (MY_IDX >= rm_idx)) begin
      data <= upper_data;
    end
  end

  assign pick = (op.remove && (rm_idx == MY_IDX)) ? data : '0;

endmodule

// ----- rtl/gawc_gather.sv -----
// two-level or-tree that collects the word picked out of the cell chain
module gawc_gather #(
  parameter int DEPTH = 64,
  parameter int EW    = 32
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [DEPTH-1:0][EW-1:0]  picks,
  output logic [EW-1:0]             merged
);

  localparam int GROUP = gawc_pkg::GATHER_GROUP;
  localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;

  logic [NGRP-1:0][EW-1:0] grp;
  logic [NGRP-1:0][EW-1:0] grp_next;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          grp_next[g] = grp_next[g] | picks[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_next;
    end
  end

  always_comb begin
    merged = '0;
    for (int g = 0; g < NGRP; g++) begin
      merged = merged | grp[g];
    end
  end

endmodule
